@@ rtl/ssof_pkg.sv @@
// Shared types, constants and helper functions of the scan spike outlier filter.
package ssof_pkg;

  localparam int RANGE_BITS     = 16;
  localparam int INTENSITY_BITS = 16;
  localparam int CFG_BITS       = 16;
  localparam int CMP_BITS       = (RANGE_BITS > CFG_BITS) ? RANGE_BITS : CFG_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = CFG_BITS'(100);
  localparam logic [CFG_BITS-1:0] MIN_RANGE_RESET = '0;
  localparam logic [CFG_BITS-1:0] MAX_RANGE_RESET = CFG_BITS'(65535);

  typedef enum logic [1:0] {
    KIND_FINITE = 2'd0,
    KIND_PINF   = 2'd1,
    KIND_NINF   = 2'd2,
    KIND_NAN    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MIN_RANGE = 2'd1,
    REG_MAX_RANGE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] threshold;
    logic [CFG_BITS-1:0] min_range;
    logic [CFG_BITS-1:0] max_range;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0]     range;
    logic [1:0]                kind;
    logic [INTENSITY_BITS-1:0] intensity;
    logic                      intensity_present;
    logic                      last;
    logic                      removed;
  } result_t;

  // Up to two results leave the front per accepted sample.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // True when a finite sample jumps by more than the threshold from a neighbor.
  function automatic logic jump_exceeds(input logic [RANGE_BITS-1:0] cur,
                                        input logic [RANGE_BITS-1:0] nb,
                                        input logic [1:0]            nb_kind,
                                        input logic [CFG_BITS-1:0]   thr);
    logic [RANGE_BITS-1:0] diff;
    logic                  result;
    diff = (cur >= nb) ? (cur - nb) : (nb - cur);
    if (nb_kind == KIND_NAN) begin
      result = 1'b0;
    end else if (nb_kind != KIND_FINITE) begin
      result = 1'b1;
    end else begin
      result = CMP_BITS'(diff) > CMP_BITS'(thr);
    end
    return result;
  endfunction

endpackage

@@ rtl/ssof_front.sv @@
// Front part: accepts samples, holds one, decides removal and pushes results.
module ssof_front import ssof_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RANGE_BITS-1:0]     range_value,
  input  logic [1:0]                range_kind,
  input  logic [INTENSITY_BITS-1:0] intensity,
  input  logic                      intensity_present,
  input  logic                      last_in_scan,
  input  logic                      space_ok,
  output push_t                     push
);

  logic [RANGE_BITS-1:0]     prev_out_range;
  logic [1:0]                prev_out_kind;
  logic [RANGE_BITS-1:0]     held_range;
  logic [1:0]                held_kind;
  logic [INTENSITY_BITS-1:0] held_intensity;
  logic                      held_has_intensity;
  logic                      held_valid;
  logic                      held_is_first;

  logic    accept;
  logic    in_window;
  logic    removed;
  result_t held_res;
  result_t new_res;

  assign in_ready = space_ok;
  assign accept   = in_valid && space_ok;

  assign in_window = (CMP_BITS'(held_range) >= CMP_BITS'(cfg.min_range)) &&
                     (CMP_BITS'(held_range) <= CMP_BITS'(cfg.max_range));

  assign removed = held_valid && !held_is_first && (held_kind == KIND_FINITE) && in_window &&
                   jump_exceeds(held_range, prev_out_range, prev_out_kind, cfg.threshold) &&
                   jump_exceeds(held_range, range_value, range_kind, cfg.threshold);

  always_comb begin
    held_res.range             = removed ? '0 : held_range;
    held_res.kind              = removed ? KIND_PINF : held_kind;
    held_res.intensity         = (removed || !held_has_intensity) ? '0 : held_intensity;
    held_res.intensity_present = held_has_intensity;
    held_res.last              = 1'b0;
    held_res.removed           = removed;

    new_res.range             = range_value;
    new_res.kind              = range_kind;
    new_res.intensity         = intensity_present ? intensity : '0;
    new_res.intensity_present = intensity_present;
    new_res.last              = 1'b1;
    new_res.removed           = 1'b0;

    push.count  = accept ? (2'(held_valid) + 2'(last_in_scan)) : 2'd0;
    push.first  = held_valid ? held_res : new_res;
    push.second = new_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_is_first  <= 1'b0;
      prev_out_range <= '0;
      prev_out_kind  <= KIND_FINITE;
    end else if (accept) begin
      if (held_valid) begin
        prev_out_range <= held_res.range;
        prev_out_kind  <= held_res.kind;
      end
      if (last_in_scan) begin
        held_valid    <= 1'b0;
        held_is_first <= 1'b0;
      end else begin
        held_is_first <= !held_valid;
        held_valid    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_in_scan) begin
      held_range         <= range_value;
      held_kind          <= range_kind;
      held_intensity     <= intensity;
      held_has_intensity <= intensity_present;
    end
  end

endmodule

@@ rtl/ssof_queue.sv @@
// Short result queue between front and back: up to two writes and one read per cycle.
module ssof_queue import ssof_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    space_ok,
  input  logic    pop,
  output logic    not_empty,
  output result_t head
);

  result_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic [QCNT_BITS-1:0] count_next;

  assign space_ok   = count <= QCNT_BITS'(QUEUE_DEPTH - 2);
  assign not_empty  = count != '0;
  assign head       = entries[rd_ptr];
  assign count_next = count + QCNT_BITS'(push.count) - QCNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push.count);
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_BITS'(1)] <= push.second;
    end
  end

endmodule

@@ rtl/ssof_back.sv @@
// Back part: output register that drains the result queue one beat at a time.
module ssof_back import ssof_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    not_empty,
  input  result_t head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign pop = not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= head;
    end
  end

endmodule

@@ rtl/scan_spike_outlier_filter_unit.sv @@
// Top level of the scan spike outlier filter: registers, front, queue and back.
//
// This block filters a stream of lidar scan samples, one sample per input beat,
// and removes isolated spikes: an inner sample of a scan that is finite, lies
// inside [min_range, max_range] and jumps by more than the jump threshold from
// both its already filtered predecessor and its raw successor is replaced by
// plus infinity with zero range and zero intensity, and out_removed is set.
// Infinite neighbors always count as a jump, NaN neighbors never do. The
// first and last samples of a scan pass unchanged. Because a decision needs
// the successor, output lags by one sample: a sample leaves when the next one
// arrives, and the last sample of a scan (last_in_scan) releases two output
// beats, its predecessor and itself. Throughput is one sample per cycle for
// scans of useful length while the output is ready; the single output register
// limits the rate to one result beat per cycle, so the extra beat of each scan
// end is absorbed by the four-entry result queue between the decision logic and
// the output. The input accepts whenever the queue has room for two results, so
// the input stays ready while a finished result waits at the output. After the
// successor's accept, the result is written into the queue and then into the
// output register. The registers are written through the cfg channel, which is
// always ready; indexes beyond the last register are ignored. Write them only
// while idle.
module scan_spike_outlier_filter_unit import ssof_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write channel.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  // Sample input channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RANGE_BITS-1:0]     range_value,
  input  logic [1:0]                range_kind,
  input  logic [INTENSITY_BITS-1:0] intensity,
  input  logic                      intensity_present,
  input  logic                      last_in_scan,
  // Result output channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RANGE_BITS-1:0]     out_range,
  output logic [1:0]                out_kind,
  output logic [INTENSITY_BITS-1:0] out_intensity,
  output logic                      out_intensity_present,
  output logic                      out_last,
  output logic                      out_removed
);

  cfg_t    cfg;
  push_t   push;
  logic    space_ok;
  logic    pop;
  logic    not_empty;
  result_t head;
  result_t out_res;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  // Register writes; an unknown index falls through the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.min_range <= MIN_RANGE_RESET;
      cfg.max_range <= MAX_RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold <= cfg_data;
        REG_MIN_RANGE: cfg.min_range <= cfg_data;
        REG_MAX_RANGE: cfg.max_range <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: holds one sample and decides whether it is an isolated outlier.
  ssof_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .range_value       (range_value),
    .range_kind        (range_kind),
    .intensity         (intensity),
    .intensity_present (intensity_present),
    .last_in_scan      (last_in_scan),
    .space_ok          (space_ok),
    .push              (push)
  );

  // Queue: decouples the decision from output back pressure.
  ssof_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Back: registered output beat.
  ssof_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_range             = out_res.range;
  assign out_kind              = out_res.kind;
  assign out_intensity         = out_res.intensity;
  assign out_intensity_present = out_res.intensity_present;
  assign out_last              = out_res.last;
  assign out_removed           = out_res.removed;

endmodule

@@ rtl/ssof_checker.sv @@
// Port-level checker of the scan spike outlier filter and its bind.
module ssof_checker import ssof_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [RANGE_BITS-1:0]     out_range,
  input logic [1:0]                out_kind,
  input logic [INTENSITY_BITS-1:0] out_intensity,
  input logic                      out_intensity_present,
  input logic                      out_last,
  input logic                      out_removed
);

  // A stalled output beat keeps its range, kind, intensity, last and removed fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_range) && $stable(out_kind) &&
      $stable(out_intensity) && $stable(out_removed) && $stable(out_last))
    else $error("output beat changed while stalled");

  // A removed sample reads as plus infinity with no range and no intensity.
  a_removed_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_removed |->
      out_kind == KIND_PINF && out_range == '0 && out_intensity == '0)
    else $error("removed sample not replaced by plus infinity");

  // Without an intensity entry the intensity reads zero.
  a_absent_intensity: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_intensity_present |-> out_intensity == '0)
    else $error("intensity not zero while absent");

  // The last sample of a scan is never removed.
  a_last_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> !out_removed)
    else $error("last sample of scan was removed");

endmodule

bind scan_spike_outlier_filter_unit ssof_checker u_ssof_checker (
  .clk                   (clk),
  .rst                   (rst),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_range             (out_range),
  .out_kind              (out_kind),
  .out_intensity         (out_intensity),
  .out_intensity_present (out_intensity_present),
  .out_last              (out_last),
  .out_removed           (out_removed)
);

@@ tb/tb_scan_spike_outlier_filter_unit.sv @@
// Self-checking testbench for the scan spike outlier filter with its own sample predictor.
module tb_scan_spike_outlier_filter_unit import ssof_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // The run aborts with a failure if it is still going after this many cycles.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the deliberate output back-pressure episode, in cycles.
  localparam int HOLD_CYCLES = 400;
  // Quiet cycles before a register write. A result shows only after the queue and
  // the output register, and a beat that causes no result may still be in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int MAX_REPORTS = 10;
  // Index 3 maps to no register and must leave every setting untouched.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One input sample as it is placed on the input channel.
  typedef struct {
    logic [RANGE_BITS-1:0]     rng;
    kind_t                     knd;
    logic [INTENSITY_BITS-1:0] inten;
    logic                      has;
    logic                      last;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = '0;
  logic [CFG_BITS-1:0]       cfg_data = '0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [RANGE_BITS-1:0]     range_value = '0;
  logic [1:0]                range_kind = '0;
  logic [INTENSITY_BITS-1:0] intensity = '0;
  logic                      intensity_present = 1'b0;
  logic                      last_in_scan = 1'b0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [RANGE_BITS-1:0]     out_range;
  logic [1:0]                out_kind;
  logic [INTENSITY_BITS-1:0] out_intensity;
  logic                      out_intensity_present;
  logic                      out_last;
  logic                      out_removed;

  scan_spike_outlier_filter_unit u_dut (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .range_value           (range_value),
    .range_kind            (range_kind),
    .intensity             (intensity),
    .intensity_present     (intensity_present),
    .last_in_scan          (last_in_scan),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_range             (out_range),
    .out_kind              (out_kind),
    .out_intensity         (out_intensity),
    .out_intensity_present (out_intensity_present),
    .out_last              (out_last),
    .out_removed           (out_removed)
  );

  always #5 clk = ~clk;

  // Samples waiting to be offered, and the filtered beats we expect back,
  // oldest first.
  sample_t pending_samples[$];
  result_t filtered_beats[$];

  // Mirror of the three registers, starting at their reset values.
  logic [CFG_BITS-1:0] thr_setting = THRESHOLD_RESET;
  logic [CFG_BITS-1:0] min_setting = MIN_RANGE_RESET;
  logic [CFG_BITS-1:0] max_setting = MAX_RANGE_RESET;

  // Predictor state. The previous neighbor is the filtered value that left
  // the block, while the held sample is the raw one still waiting for its
  // successor before its fate can be decided.
  logic [RANGE_BITS-1:0]     emitted_rng = '0;
  logic [1:0]                emitted_knd = KIND_FINITE;
  logic [RANGE_BITS-1:0]     held_rng = '0;
  logic [1:0]                held_knd = KIND_FINITE;
  logic [INTENSITY_BITS-1:0] held_inten = '0;
  logic                      held_has = 1'b0;
  logic                      held_ok = 1'b0;
  logic                      held_first = 1'b0;

  // Bookkeeping shared by the stimulus, driver and monitor.
  int  samples_queued = 0;
  int  samples_taken = 0;
  int  beats_checked = 0;
  int  spikes_predicted = 0;
  int  scans_queued = 0;
  int  settings_used = 1;
  int  fault_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  int  hold_requests = 0;

  // Random scan generator state. A scan may run across a register change,
  // which checks that new settings apply to the very next decision.
  int  scan_left = 0;
  int  scan_base = 0;

  // True when a finite sample differs from a neighbor by more than the
  // threshold. Infinite neighbors always count as a jump, NaN never does.
  function automatic bit far_from(input logic [RANGE_BITS-1:0] here,
                                  input logic [RANGE_BITS-1:0] there,
                                  input logic [1:0] there_knd);
    logic [RANGE_BITS-1:0] gap;
    gap = (here >= there) ? here - there : there - here;
    case (there_knd)
      KIND_FINITE: return gap > thr_setting;
      KIND_NAN:    return 1'b0;
      default:     return 1'b1;
    endcase
  endfunction

  // Advances the predictor by one accepted sample and queues the beats it
  // releases: the decided predecessor, and the sample itself on a scan end.
  function automatic void filter_sample(input sample_t s);
    result_t beat;
    bit      spike;
    if (held_ok) begin
      spike = !held_first && held_knd == KIND_FINITE &&
              held_rng >= min_setting && held_rng <= max_setting &&
              far_from(held_rng, emitted_rng, emitted_knd) &&
              far_from(held_rng, s.rng, s.knd);
      beat.range             = spike ? '0 : held_rng;
      beat.kind              = spike ? KIND_PINF : held_knd;
      beat.intensity         = (spike || !held_has) ? '0 : held_inten;
      beat.intensity_present = held_has;
      beat.last              = 1'b0;
      beat.removed           = spike;
      filtered_beats.push_back(beat);
      emitted_rng = beat.range;
      emitted_knd = beat.kind;
      if (spike) spikes_predicted++;
    end
    if (s.last) begin
      beat.range             = s.rng;
      beat.kind              = s.knd;
      beat.intensity         = s.has ? s.inten : '0;
      beat.intensity_present = s.has;
      beat.last              = 1'b1;
      beat.removed           = 1'b0;
      filtered_beats.push_back(beat);
      held_ok    = 1'b0;
      held_first = 1'b0;
    end else begin
      held_first = !held_ok;
      held_ok    = 1'b1;
      held_rng   = s.rng;
      held_knd   = s.knd;
      held_inten = s.inten;
      held_has   = s.has;
    end
  endfunction

  // Input driver. A beat is taken at the edge where valid and ready were
  // both high; the predictor runs right there, so the expectations always
  // use the settings that the block holds at that moment. A new sample is
  // put on the bus only once the previous one is gone, and about a third of
  // the free slots are left empty unless the calm stretch is on.
  always @(posedge clk) begin : sample_feeder
    sample_t taken;
    sample_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.rng   = range_value;
        taken.knd   = kind_t'(range_kind);
        taken.inten = intensity;
        taken.has   = intensity_present;
        taken.last  = last_in_scan;
        filter_sample(taken);
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          nxt = pending_samples.pop_front();
          in_valid          <= 1'b1;
          range_value       <= nxt.rng;
          range_kind        <= nxt.knd;
          intensity         <= nxt.inten;
          intensity_present <= nxt.has;
          last_in_scan      <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Every beat taken is compared field by field with the
  // oldest expectation. Ready drops at random, and once on request it stays
  // low for a long stretch so that the result queue fills and the block has
  // to push back on its input while the driver keeps offering samples.
  always @(posedge clk) begin : result_checker
    int      hold_left;
    int      holds_served;
    result_t want;
    bit      wrong;
    if (rst) begin
      out_ready    <= 1'b0;
      hold_left    = 0;
      holds_served = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (filtered_beats.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("beat %0d arrived with nothing expected: range %0d kind %0d",
                     beats_checked, out_range, out_kind);
        end else begin
          want  = filtered_beats.pop_front();
          wrong = (out_range !== want.range) || (out_kind !== want.kind) ||
                  (out_intensity !== want.intensity) ||
                  (out_intensity_present !== want.intensity_present) ||
                  (out_last !== want.last) || (out_removed !== want.removed);
          if (wrong) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display({"beat %0d mismatch, expected range %0d kind %0d int %0d ",
                        "pres %b last %b rem %b"},
                       beats_checked, want.range, want.kind, want.intensity,
                       want.intensity_present, want.last, want.removed);
              $display("  got range %0d kind %0d int %0d pres %b last %b rem %b",
                       out_range, out_kind, out_intensity, out_intensity_present,
                       out_last, out_removed);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // Watchdog: a lost result or a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles: %0d of %0d samples taken, %0d beats outstanding",
               cycle_count, samples_taken, samples_queued, filtered_beats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_sample(input int rng, input kind_t knd, input int inten,
                            input bit has, input bit last);
    sample_t s;
    s.rng   = RANGE_BITS'(rng);
    s.knd   = knd;
    s.inten = INTENSITY_BITS'(inten);
    s.has   = has;
    s.last  = last;
    pending_samples.push_back(s);
    samples_queued++;
    if (last) scans_queued++;
  endtask

  // Waits until every queued sample was taken and every expected beat
  // arrived, then lets the pipeline drain before anything else happens.
  task automatic wait_until_drained();
    while (samples_taken != samples_queued || filtered_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers in back-to-back beats, optionally followed by
  // a write to the unused index, which the block has to ignore.
  task automatic set_filter(input logic [CFG_BITS-1:0] thr,
                            input logic [CFG_BITS-1:0] lo,
                            input logic [CFG_BITS-1:0] hi,
                            input bit poke_unused);
    logic [1:0]          idx[4];
    logic [CFG_BITS-1:0] dat[4];
    int                  n;
    idx[0] = REG_THRESHOLD;  dat[0] = thr;
    idx[1] = REG_MIN_RANGE;  dat[1] = lo;
    idx[2] = REG_MAX_RANGE;  dat[2] = hi;
    idx[3] = REG_UNUSED;     dat[3] = CFG_BITS'($urandom_range(65535));
    n = poke_unused ? 4 : 3;
    cfg_valid <= 1'b1;
    cfg_index <= idx[0];
    cfg_data  <= dat[0];
    for (int i = 0; i < n; i++) begin
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_THRESHOLD: thr_setting = dat[i];
        REG_MIN_RANGE: min_setting = dat[i];
        REG_MAX_RANGE: max_setting = dat[i];
        default: ;
      endcase
      if (i + 1 < n) begin
        cfg_index <= idx[i + 1];
        cfg_data  <= dat[i + 1];
      end else begin
        cfg_valid <= 1'b0;
      end
    end
    settings_used++;
  endtask

  // Random scans. Most samples wander around a base inside the valid range
  // window, some are spikes placed right at or just past the threshold or far
  // away, some are fully random, and a few carry an infinite or NaN kind.
  // Scan lengths are mostly short so that edges occur often, with one- and
  // two-sample scans mixed in.
  task automatic add_random_scans(input int count);
    int    pick;
    int    val;
    int    thr;
    kind_t knd;
    thr = thr_setting;
    for (int i = 0; i < count; i++) begin
      if (scan_left == 0) begin
        pick = $urandom_range(99);
        if (pick < 5) scan_left = 1;
        else if (pick < 10) scan_left = 2;
        else if (pick < 13) scan_left = $urandom_range(120, 60);
        else scan_left = $urandom_range(24, 3);
        scan_base = (min_setting <= max_setting) ?
                    $urandom_range(max_setting, min_setting) : $urandom_range(65535);
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        val = scan_base + ($urandom_range(1) ? 1 : -1) * (thr + $urandom_range(2));
      end else if (pick < 20) begin
        val = scan_base + ($urandom_range(1) ? 1 : -1) * $urandom_range(65535);
      end else if (pick < 28) begin
        val = $urandom_range(65535);
      end else begin
        val = scan_base + $urandom_range(thr / 2) - thr / 4;
        if ($urandom_range(9) == 0) scan_base = val;
      end
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      pick = $urandom_range(99);
      if (pick < 86) knd = KIND_FINITE;
      else if (pick < 91) knd = KIND_PINF;
      else if (pick < 95) knd = KIND_NINF;
      else knd = KIND_NAN;
      add_sample(val, knd, $urandom_range(65535), $urandom_range(3) != 0, scan_left == 1);
      scan_left--;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: threshold 100, window 0 to 65535.
    // A one-sample scan, passed through untouched.
    add_sample(0, KIND_FINITE, 65535, 1'b1, 1'b1);
    // A two-sample scan; the second has a stale intensity that must read as 0.
    add_sample(65535, KIND_FINITE, 0, 1'b1, 1'b0);
    add_sample(0, KIND_FINITE, 1234, 1'b0, 1'b1);
    // A clear spike, then a sample whose predecessor is the infinity that
    // replaced the spike, while its successor sits exactly at the threshold.
    add_sample(1000, KIND_FINITE, 10, 1'b1, 1'b0);
    add_sample(5000, KIND_FINITE, 65535, 1'b1, 1'b0);
    add_sample(1000, KIND_FINITE, 20, 1'b1, 1'b0);
    add_sample(1100, KIND_FINITE, 30, 1'b1, 1'b1);
    // Infinite neighbors on both sides remove a sample; a NaN neighbor
    // protects one; infinite and NaN samples themselves are never removed.
    add_sample(2000, KIND_FINITE, 1, 1'b1, 1'b0);
    add_sample(65535, KIND_PINF, 2, 1'b1, 1'b0);
    add_sample(3000, KIND_FINITE, 3, 1'b1, 1'b0);
    add_sample(21845, KIND_NINF, 4, 1'b1, 1'b0);
    add_sample(43690, KIND_NAN, 5, 1'b1, 1'b0);
    add_sample(4000, KIND_FINITE, 6, 1'b1, 1'b0);
    add_sample(0, KIND_FINITE, 7, 1'b1, 1'b1);
    // Full-scale swings: two removals in a row, the second one triggered by
    // the infinity that the first left behind.
    add_sample(0, KIND_FINITE, 65535, 1'b1, 1'b0);
    add_sample(65535, KIND_FINITE, 65535, 1'b1, 1'b0);
    add_sample(0, KIND_FINITE, 65535, 1'b0, 1'b0);
    add_sample(65535, KIND_FINITE, 0, 1'b1, 1'b1);
    // A spike without an intensity entry.
    add_sample(500, KIND_FINITE, 777, 1'b1, 1'b0);
    add_sample(9000, KIND_FINITE, 777, 1'b0, 1'b0);
    add_sample(500, KIND_FINITE, 777, 1'b1, 1'b1);
    wait_until_drained();

    // Random phases, each under a different setting. The last scan of a
    // phase is often left open, so register changes also land mid scan.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_filter(16'd0, 16'd0, 16'd65535, 1'b0);
        1: set_filter(16'd65535, 16'd0, 16'd65535, 1'b0);
        2: set_filter(16'd500, 16'd2000, 16'd40000, 1'b0);
        // Minimum above maximum: no sample is in range, nothing is removed.
        3: set_filter(16'd200, 16'd50000, 16'd1000, 1'b0);
        4: set_filter(16'd300, 16'd65535, 16'd65535, 1'b0);
        5: set_filter(THRESHOLD_RESET, MIN_RANGE_RESET, MAX_RANGE_RESET, 1'b1);
        default: set_filter(CFG_BITS'($urandom_range(2000)),
                            CFG_BITS'($urandom_range(20000)),
                            CFG_BITS'($urandom_range(65535, 20000)), 1'b1);
      endcase
      // One phase runs without any idle cycles on either side, and another
      // one starts with the long output hold.
      calm = (phase == 2);
      if (phase == 4) hold_requests++;
      add_random_scans(PHASE_ITEMS);
      wait_until_drained();
    end

    $display("%0d samples in %0d scans fed through %0d register settings, %0d beats checked",
             samples_taken, scans_queued, settings_used, beats_checked);
    $display("%0d samples were expected to be removed as spikes, %0d checks failed",
             spikes_predicted, fault_count);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ssof_pkg.sv
rtl/ssof_front.sv
rtl/ssof_queue.sv
rtl/ssof_back.sv
rtl/scan_spike_outlier_filter_unit.sv
rtl/ssof_checker.sv
tb/tb_scan_spike_outlier_filter_unit.sv
